FILE: src/fgd_pkg.sv
package fgd_pkg;

   localparam int DIV_W  = 40;
   localparam int DVSR_W = 32;
   localparam int MUL_AW = 24;
   localparam int MUL_BW = 16;
   localparam int MUL_W  = MUL_AW + MUL_BW;

   localparam logic [1:0] EV_PRESS   = 2'd0;
   localparam logic [1:0] EV_RELEASE = 2'd1;
   localparam logic [1:0] EV_MOVE    = 2'd2;

   localparam logic [2:0] CSR_MIN_VEL   = 3'd0;
   localparam logic [2:0] CSR_MAX_VEL   = 3'd1;
   localparam logic [2:0] CSR_DRAG_DIST = 3'd2;
   localparam logic [2:0] CSR_SCROLL_MS = 3'd3;
   localparam logic [2:0] CSR_PAUSE_MS  = 3'd4;

   localparam logic [23:0] VEL_SAT       = 24'hFFFFFF;
   localparam logic [16:0] MOVE_THRESH   = 17'd5;
   localparam logic [31:0] MS_PER_SEC    = 32'd1000;
   localparam logic [39:0] ROUND_HALF    = 40'd500;

   typedef logic signed [24:0] vel_type;

endpackage

FILE: src/fgd_div.sv
module fgd_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fgd_pkg::DIV_W-1:0]     dividend,
   input  logic [fgd_pkg::DVSR_W-1:0]    divisor,
   output logic                          done,
   output logic [fgd_pkg::DIV_W-1:0]     quotient
);
   import fgd_pkg::*;

   logic [DVSR_W:0]   rem_ff, rem_in, rem_sh;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              fits;

   // restoring division, one quotient bit a cycle
   always_comb begin
      rem_sh  = {rem_ff[DVSR_W-1:0], quo_ff[DIV_W-1]};
      fits    = rem_sh >= {1'b0, divisor};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? rem_sh - {1'b0, divisor} : rem_sh;
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

FILE: src/fgd_mul.sv
module fgd_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fgd_pkg::MUL_AW-1:0]    a,
   input  logic [fgd_pkg::MUL_BW-1:0]    b,
   output logic                          done,
   output logic [fgd_pkg::MUL_W-1:0]     product
);
   import fgd_pkg::*;

   logic [MUL_W-1:0]  acc_ff, acc_in, ash_ff, ash_in;
   logic [MUL_BW-1:0] bsh_ff, bsh_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   // shift-add, one multiplier bit a cycle
   always_comb begin
      acc_in  = acc_ff;
      ash_in  = ash_ff;
      bsh_in  = bsh_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         ash_in  = {{MUL_BW{1'b0}}, a};
         bsh_in  = b;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (bsh_ff[0]) acc_in = acc_ff + ash_ff;
         ash_in = {ash_ff[MUL_W-2:0], 1'b0};
         bsh_in = {1'b0, bsh_ff[MUL_BW-1:1]};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(MUL_BW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      ash_ff <= ash_in;
      bsh_ff <= bsh_in;
      cnt_ff <= cnt_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule

FILE: src/fling_gesture_detector_core.sv
// fling detector for pointer events
// req channel: one beat per pointer event (press, release, move) with position
//   and a millisecond timestamp. rsp channel: exactly one beat per event; fling
//   is set only on a release that qualifies, else all fields are zero.
// csr port: write-only, takes effect at once; write only while idle.
// press, unknown kinds, releases that do not fling and other moves go straight to
//   the output write state. a move longer than 5 pixels during a press runs two
//   serial divisions (x then y) for the velocities. a fling release runs, per
//   axis, a serial multiply and a serial divide by 1000. one event is in work
//   at a time.
// the result sits in an output register, so the next event is taken while it
//   waits; a stalled receiver holds the block only when a second result is due.
// reset (synchronous, active high) clears the gesture state, loads the default
//   register values and empties the output.
module fling_gesture_detector_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic [31:0]        req_now_ms,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_fling,
   output logic signed [15:0] rsp_start_x,
   output logic signed [15:0] rsp_start_y,
   output logic signed [31:0] rsp_end_x,
   output logic signed [31:0] rsp_end_y,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_wdata
);
   import fgd_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIVX  = 3'd1;
   localparam logic [2:0] ST_DIVY  = 3'd2;
   localparam logic [2:0] ST_MULX  = 3'd3;
   localparam logic [2:0] ST_DVPX  = 3'd4;
   localparam logic [2:0] ST_MULY  = 3'd5;
   localparam logic [2:0] ST_DVPY  = 3'd6;
   localparam logic [2:0] ST_WRITE = 3'd7;

   logic [23:0] min_vel_ff, max_vel_ff, drag_min_ff;
   logic [15:0] scroll_ff, pause_ff;

   logic [2:0]         state_ff, state_in;
   logic               started_ff, started_in;
   logic signed [15:0] last_x_ff, last_x_in, last_y_ff, last_y_in;
   logic               pressed_ff, pressed_in;
   vel_type            vel_x_ff, vel_x_in, vel_y_ff, vel_y_in;
   logic [23:0]        drag_ff, drag_in;
   logic [31:0]        mark_ff, mark_in, elapsed_ff, elapsed_in;
   logic signed [16:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [MUL_W-1:0]   prod_ff, prod_in;
   logic               fling_ff, fling_in;
   logic signed [31:0] end_x_ff, end_x_in, end_y_ff, end_y_in;

   logic               out_valid_ff;
   logic               out_fling_ff;
   logic signed [15:0] out_sx_ff, out_sy_ff;
   logic signed [31:0] out_ex_ff, out_ey_ff;
   logic               out_load;

   logic               div_start, div_done, mul_start, mul_done;
   logic [DIV_W-1:0]   div_dividend, div_q;
   logic [DVSR_W-1:0]  div_divisor;
   logic [MUL_AW-1:0]  mul_a;
   logic [MUL_W-1:0]   mul_p;

   logic signed [16:0] mv_dx, mv_dy;
   logic [15:0]        adx, ady;
   logic [16:0]        man;
   logic [24:0]        dsum;
   logic [31:0]        rel_elapsed;
   logic [23:0]        mag_x, mag_y, cmag_x, cmag_y;
   logic               fling_ok;
   logic [15:0]        dmag;
   logic [25:0]        dmag_k;
   logic [23:0]        qsat;
   vel_type            vnew;
   logic [31:0]        proj;
   logic signed [31:0] end_val;

   function automatic logic [23:0] vmag(input vel_type v);
      vel_type n;
      n = -v;
      return v[24] ? n[23:0] : v[23:0];
   endfunction

   function automatic logic [23:0] vclamp(input logic [23:0] m, input logic [23:0] lim);
      return (lim != '0 && m > lim) ? lim : m;
   endfunction

   function automatic vel_type vsign(input logic neg, input logic [23:0] m);
      vel_type p;
      p = vel_type'({1'b0, m});
      return neg ? -p : p;
   endfunction

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_vel_ff  <= 24'd120;
         max_vel_ff  <= 24'd80;
         drag_min_ff <= 24'd40;
         scroll_ff   <= 16'd3000;
         pause_ff    <= 16'd300;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MIN_VEL:   min_vel_ff  <= csr_wdata;
            CSR_MAX_VEL:   max_vel_ff  <= csr_wdata;
            CSR_DRAG_DIST: drag_min_ff <= csr_wdata;
            CSR_SCROLL_MS: if (csr_wdata[15:0] != '0) scroll_ff <= csr_wdata[15:0];
            CSR_PAUSE_MS:  pause_ff    <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign out_load  = (state_ff == ST_WRITE) && (!out_valid_ff || rsp_ready);

   always_comb begin
      mv_dx       = 17'(req_pos_x) - 17'(last_x_ff);
      mv_dy       = 17'(req_pos_y) - 17'(last_y_ff);
      adx         = mv_dx[16] ? 16'(-mv_dx) : mv_dx[15:0];
      ady         = mv_dy[16] ? 16'(-mv_dy) : mv_dy[15:0];
      man         = {1'b0, adx} + {1'b0, ady};
      dsum        = {1'b0, drag_ff} + 25'(man);
      rel_elapsed = req_now_ms - mark_ff;
      mag_x       = vmag(vel_x_ff);
      mag_y       = vmag(vel_y_ff);
      cmag_x      = vclamp(mag_x, max_vel_ff);
      cmag_y      = vclamp(mag_y, max_vel_ff);
      fling_ok    = pressed_ff && rel_elapsed <= {16'd0, pause_ff}
                    && drag_ff >= drag_min_ff
                    && (mag_x >= min_vel_ff || mag_y >= min_vel_ff);

      // delta magnitude times 1000 as 1024 - 16 - 8
      dmag   = (state_ff == ST_DIVY) ? (dy_ff[16] ? 16'(-dy_ff) : dy_ff[15:0])
                                     : (dx_ff[16] ? 16'(-dx_ff) : dx_ff[15:0]);
      dmag_k = {dmag, 10'd0} - {6'd0, dmag, 4'd0} - {7'd0, dmag, 3'd0};
      qsat   = (div_q > DIV_W'(VEL_SAT)) ? VEL_SAT : div_q[23:0];
      proj   = div_q[31:0];

      div_dividend = (state_ff == ST_DIVX || state_ff == ST_DIVY)
                     ? DIV_W'(dmag_k) : prod_ff + ROUND_HALF;
      div_divisor  = (state_ff == ST_DIVX || state_ff == ST_DIVY)
                     ? elapsed_ff : MS_PER_SEC;
      mul_a        = (state_ff == ST_MULY) ? vmag(vel_y_ff) : vmag(vel_x_ff);
      div_start    = !started_ff && (state_ff == ST_DIVX || state_ff == ST_DIVY
                     || state_ff == ST_DVPX || state_ff == ST_DVPY);
      mul_start    = !started_ff && (state_ff == ST_MULX || state_ff == ST_MULY);

      state_in   = state_ff;
      started_in = started_ff;
      last_x_in  = last_x_ff;
      last_y_in  = last_y_ff;
      pressed_in = pressed_ff;
      vel_x_in   = vel_x_ff;
      vel_y_in   = vel_y_ff;
      drag_in    = drag_ff;
      mark_in    = mark_ff;
      elapsed_in = elapsed_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      prod_in    = prod_ff;
      fling_in   = fling_ff;
      end_x_in   = end_x_ff;
      end_y_in   = end_y_ff;
      vnew       = '0;
      end_val    = '0;

      if (div_start || mul_start) started_in = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               fling_in = 1'b0;
               end_x_in = '0;
               end_y_in = '0;
               state_in = ST_WRITE;
               case (req_type)
                  EV_PRESS: begin
                     last_x_in  = req_pos_x;
                     last_y_in  = req_pos_y;
                     pressed_in = 1'b1;
                     vel_x_in   = '0;
                     vel_y_in   = '0;
                     drag_in    = '0;
                     mark_in    = req_now_ms;
                  end
                  EV_RELEASE: begin
                     pressed_in = 1'b0;
                     if (fling_ok) begin
                        vel_x_in = vsign(vel_x_ff[24], cmag_x);
                        vel_y_in = vsign(vel_y_ff[24], cmag_y);
                        fling_in = 1'b1;
                        state_in = ST_MULX;
                     end
                  end
                  EV_MOVE: begin
                     if (pressed_ff) begin
                        drag_in   = dsum[24] ? VEL_SAT : dsum[23:0];
                        last_x_in = req_pos_x;
                        last_y_in = req_pos_y;
                        if (man > MOVE_THRESH) begin
                           elapsed_in = rel_elapsed;
                           mark_in    = req_now_ms;
                           dx_in      = mv_dx;
                           dy_in      = mv_dy;
                           state_in   = ST_DIVX;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_DIVX, ST_DIVY: begin
            if (div_done) begin
               started_in = 1'b0;
               if (state_ff == ST_DIVX) begin
                  vnew     = (dx_ff == '0) ? '0 : vsign(dx_ff[16], qsat);
                  vel_x_in = vnew;
                  state_in = ST_DIVY;
               end else begin
                  vnew     = (dy_ff == '0) ? '0 : vsign(dy_ff[16], qsat);
                  vel_y_in = vnew;
                  state_in = ST_WRITE;
               end
            end
         end
         ST_MULX, ST_MULY: begin
            if (mul_done) begin
               started_in = 1'b0;
               prod_in    = mul_p;
               state_in   = (state_ff == ST_MULX) ? ST_DVPX : ST_DVPY;
            end
         end
         ST_DVPX, ST_DVPY: begin
            if (div_done) begin
               started_in = 1'b0;
               if (state_ff == ST_DVPX) begin
                  end_val  = vel_x_ff[24] ? 32'(last_x_ff) - signed'(proj)
                                          : 32'(last_x_ff) + signed'(proj);
                  end_x_in = end_val;
                  state_in = ST_MULY;
               end else begin
                  end_val  = vel_y_ff[24] ? 32'(last_y_ff) - signed'(proj)
                                          : 32'(last_y_ff) + signed'(proj);
                  end_y_in = end_val;
                  state_in = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            if (out_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         started_ff   <= 1'b0;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         pressed_ff   <= 1'b0;
         vel_x_ff     <= '0;
         vel_y_ff     <= '0;
         drag_ff      <= '0;
         mark_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         started_ff <= started_in;
         last_x_ff  <= last_x_in;
         last_y_ff  <= last_y_in;
         pressed_ff <= pressed_in;
         vel_x_ff   <= vel_x_in;
         vel_y_ff   <= vel_y_in;
         drag_ff    <= drag_in;
         mark_ff    <= mark_in;
         if (out_load) out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
      end
      elapsed_ff <= elapsed_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      prod_ff    <= prod_in;
      fling_ff   <= fling_in;
      end_x_ff   <= end_x_in;
      end_y_ff   <= end_y_in;
      if (out_load) begin
         out_fling_ff <= fling_ff;
         out_sx_ff    <= fling_ff ? last_x_ff : '0;
         out_sy_ff    <= fling_ff ? last_y_ff : '0;
         out_ex_ff    <= end_x_ff;
         out_ey_ff    <= end_y_ff;
      end
   end

   fgd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   fgd_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (scroll_ff),
      .done    (mul_done),
      .product (mul_p)
   );

   assign rsp_valid   = out_valid_ff;
   assign rsp_fling   = out_fling_ff;
   assign rsp_start_x = out_sx_ff;
   assign rsp_start_y = out_sy_ff;
   assign rsp_end_x   = out_ex_ff;
   assign rsp_end_y   = out_ey_ff;
endmodule

FILE: tb/sv/fling_gesture_detector_core_test.sv
`timescale 1ns / 100ps

class fling_scoreboard;
   int unsigned min_vel, max_vel, drag_min, scroll_ms, pause_ms;
   logic signed [15:0] last_x, last_y;
   bit pressed;
   longint vel_x, vel_y;
   int unsigned drag_dist;
   logic [31:0] mark_ms;
   int errors;
   int flings;
   typedef struct {
      bit fling;
      logic signed [15:0] sx, sy;
      logic signed [31:0] ex, ey;
   } fling_result_type;
   fling_result_type pending[$];

   function new();
      min_vel = 120; max_vel = 80; drag_min = 40; scroll_ms = 3000; pause_ms = 300;
      last_x = 0; last_y = 0; pressed = 0; vel_x = 0; vel_y = 0;
      drag_dist = 0; mark_ms = 0; errors = 0; flings = 0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [23:0] val);
      case (idx)
         fgd_pkg::CSR_MIN_VEL:   min_vel = 32'(val);
         fgd_pkg::CSR_MAX_VEL:   max_vel = 32'(val);
         fgd_pkg::CSR_DRAG_DIST: drag_min = 32'(val);
         fgd_pkg::CSR_SCROLL_MS: if (val[15:0] != 0) scroll_ms = 32'(val[15:0]);
         fgd_pkg::CSR_PAUSE_MS:  pause_ms = 32'(val[15:0]);
         default: ;
      endcase
   endfunction

   function longint abs_of(longint v);
      return v < 0 ? -v : v;
   endfunction

   function longint velocity(longint delta, logic [31:0] el);
      longint q;
      if (el == 0) return delta > 0 ? 16777215 : (delta < 0 ? -16777215 : 0);
      q = (delta * 1000) / longint'(el);
      if (q > 16777215) q = 16777215;
      if (q < -16777215) q = -16777215;
      return q;
   endfunction

   function longint clamp_vel(longint v);
      if (max_vel == 0) return v;
      if (v > longint'(max_vel)) return longint'(max_vel);
      if (v < -longint'(max_vel)) return -longint'(max_vel);
      return v;
   endfunction

   function longint offset(longint v);
      longint n, r;
      n = v * longint'(scroll_ms);
      r = (abs_of(n) + 500) / 1000;
      return n < 0 ? -r : r;
   endfunction

   function void note_event(logic [1:0] kind, logic signed [15:0] px,
                            logic signed [15:0] py, logic [31:0] now);
      fling_result_type r;
      longint dx, dy, man, sum;
      logic [31:0] el;
      r = '{0, 0, 0, 0, 0};
      if (kind == fgd_pkg::EV_PRESS) begin
         last_x = px; last_y = py; pressed = 1;
         vel_x = 0; vel_y = 0; drag_dist = 0; mark_ms = now;
      end else if (kind == fgd_pkg::EV_RELEASE) begin
         el = now - mark_ms;
         if (pressed && el <= pause_ms && drag_dist >= drag_min &&
             (abs_of(vel_x) >= longint'(min_vel) || abs_of(vel_y) >= longint'(min_vel))) begin
            vel_x = clamp_vel(vel_x);
            vel_y = clamp_vel(vel_y);
            r.fling = 1; r.sx = last_x; r.sy = last_y;
            r.ex = 32'(longint'(last_x) + offset(vel_x));
            r.ey = 32'(longint'(last_y) + offset(vel_y));
            flings++;
         end
         pressed = 0;
      end else if (kind == fgd_pkg::EV_MOVE && pressed) begin
         dx = longint'(px) - last_x;
         dy = longint'(py) - last_y;
         man = abs_of(dx) + abs_of(dy);
         sum = longint'(drag_dist) + man;
         drag_dist = 32'(sum > 16777215 ? 16777215 : sum);
         last_x = px; last_y = py;
         if (man > 5) begin
            el = now - mark_ms;
            vel_x = velocity(dx, el);
            vel_y = velocity(dy, el);
            mark_ms = now;
         end
      end
      pending.push_back(r);
   endfunction

   function void check_result(bit fl, logic signed [15:0] sx, logic signed [15:0] sy,
                              logic signed [31:0] ex, logic signed [31:0] ey);
      fling_result_type e;
      if (pending.size() == 0) begin
         $error("unexpected result beat");
         errors++;
         return;
      end
      e = pending.pop_front();
      if (fl !== e.fling) begin $error("fling exp %0d got %0d", e.fling, fl); errors++; end
      if (sx !== e.sx) begin $error("start_x exp %0d got %0d", e.sx, sx); errors++; end
      if (sy !== e.sy) begin $error("start_y exp %0d got %0d", e.sy, sy); errors++; end
      if (ex !== e.ex) begin $error("end_x exp %0d got %0d", e.ex, ex); errors++; end
      if (ey !== e.ey) begin $error("end_y exp %0d got %0d", e.ey, ey); errors++; end
   endfunction
endclass

module fling_gesture_detector_core_test;
   import fgd_pkg::*;

   localparam logic [1:0] EV_UNUSED  = 2'd3;
   localparam logic [2:0] CSR_UNUSED = 3'd7;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [1:0] req_type = 0;
   logic signed [15:0] req_pos_x = 0, req_pos_y = 0;
   logic [31:0] req_now_ms = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic rsp_fling;
   logic signed [15:0] rsp_start_x, rsp_start_y;
   logic signed [31:0] rsp_end_x, rsp_end_y;
   logic csr_we = 0;
   logic [2:0] csr_index = 0;
   logic [23:0] csr_wdata = 0;

   fling_scoreboard board = new();
   int send_idle_pct = 0, recv_idle_pct = 0;
   int sent = 0;
   logic [31:0] clock_ms = 0;
   logic signed [15:0] cur_x = 0, cur_y = 0;

   fling_gesture_detector_core dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_result(rsp_fling, rsp_start_x, rsp_start_y, rsp_end_x, rsp_end_y);
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_event(logic [1:0] kind, logic signed [15:0] px,
                             logic signed [15:0] py, logic [31:0] now);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_valid <= 1; req_type <= kind; req_pos_x <= px; req_pos_y <= py;
      req_now_ms <= now;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_event(kind, px, py, now);
      sent++;
      @(negedge clock);
      req_valid <= 0;
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(negedge clock);
      repeat (150) @(negedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [23:0] val);
      @(negedge clock);
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
      board.write_reg(idx, val);
   endtask

   // a pressed drag of random steps, then a release
   task automatic gesture();
      int steps;
      logic [31:0] t;
      logic signed [15:0] nx, ny;
      cur_x = 16'($urandom); cur_y = 16'($urandom);
      if ($urandom_range(3) == 0) begin cur_x = 16'sh7ff0; cur_y = -16'sh7ff0; end
      t = clock_ms;
      send_event(EV_PRESS, cur_x, cur_y, t);
      steps = $urandom_range(1, 6);
      repeat (steps) begin
         case ($urandom_range(3))
            0: begin nx = cur_x + 16'(signed'($urandom_range(0, 12)) - 6);
                     ny = cur_y + 16'(signed'($urandom_range(0, 12)) - 6); end
            1: begin nx = cur_x + 16'(signed'($urandom_range(0, 400)) - 200);
                     ny = cur_y + 16'(signed'($urandom_range(0, 400)) - 200); end
            2: begin nx = 16'($urandom); ny = 16'($urandom); end
            default: begin nx = cur_x + 16'sd30; ny = cur_y - 16'sd7; end
         endcase
         t = t + ($urandom_range(4) == 0 ? 0 : $urandom_range(1, 120));
         if ($urandom_range(9) == 0) send_event(EV_UNUSED, nx, ny, t);
         else send_event(EV_MOVE, nx, ny, t);
         cur_x = nx; cur_y = ny;
      end
      t = t + ($urandom_range(5) == 0 ? $urandom_range(200, 2000) : $urandom_range(0, 60));
      send_event(EV_RELEASE, 16'($urandom), 16'($urandom), t);
      clock_ms = t + $urandom_range(0, 5000);
   endtask

   task automatic random_settings(int extreme);
      case (extreme)
         0: begin
            write_csr(CSR_MIN_VEL, 24'($urandom_range(0, 3000)));
            write_csr(CSR_MAX_VEL, 24'($urandom_range(0, 1) ? 0 : $urandom_range(1, 50000)));
            write_csr(CSR_DRAG_DIST, 24'($urandom_range(0, 300)));
            write_csr(CSR_SCROLL_MS, 24'($urandom_range(1, 65535)));
            write_csr(CSR_PAUSE_MS, 24'($urandom_range(50, 3000)));
         end
         1: begin
            write_csr(CSR_MIN_VEL, 0); write_csr(CSR_MAX_VEL, 0);
            write_csr(CSR_DRAG_DIST, 0); write_csr(CSR_SCROLL_MS, 24'hFFFF);
            write_csr(CSR_PAUSE_MS, 24'hFFFF);
         end
         default: begin
            write_csr(CSR_MIN_VEL, 24'hFFFFFF); write_csr(CSR_MAX_VEL, 24'hFFFFFF);
            write_csr(CSR_DRAG_DIST, 24'hFFFFFF); write_csr(CSR_SCROLL_MS, 1);
            write_csr(CSR_PAUSE_MS, 0);
         end
      endcase
   endtask

   initial begin
      #50_000_000;
      $display("fling_gesture_detector_core_test failed");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: defaults
      send_event(EV_RELEASE, 5, 5, 10);
      send_event(EV_MOVE, 100, 100, 20);
      send_event(EV_UNUSED, 16'sh7fff, -16'sh8000, 32'hFFFFFFFF);
      send_event(EV_PRESS, 0, 0, 32'hFFFFFFF0);
      send_event(EV_MOVE, 3, 2, 32'hFFFFFFF5);
      send_event(EV_MOVE, 60, -10, 32'h00000010);
      send_event(EV_RELEASE, 0, 0, 32'h00000020);
      send_event(EV_PRESS, -16'sh8000, 16'sh7fff, 100);
      send_event(EV_MOVE, 16'sh7fff, -16'sh8000, 100);
      send_event(EV_MOVE, 16'sh7fff, 16'sh7fff, 100);
      send_event(EV_RELEASE, 0, 0, 100);
      send_event(EV_PRESS, 10, 10, 1000);
      send_event(EV_MOVE, 80, 10, 1200);
      send_event(EV_RELEASE, 0, 0, 1600);
      drain();
      write_csr(CSR_SCROLL_MS, 0);
      write_csr(CSR_UNUSED, 24'h123456);
      random_settings(1);
      send_event(EV_PRESS, 16'sh7fff, 16'sh7fff, 0);
      send_event(EV_MOVE, -16'sh8000, -16'sh8000, 0);
      send_event(EV_RELEASE, 0, 0, 32'hFFFF);
      send_event(EV_PRESS, 1, 1, 0);
      send_event(EV_MOVE, 1, 1, 0);
      send_event(EV_RELEASE, 0, 0, 0);
      drain();

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = ph == 0 ? 14 : (ph == 1 ? 82 : 0);
         recv_idle_pct = ph == 0 ? 82 : (ph == 1 ? 14 : 0);
         for (int k = 0; k < 6; k++) begin
            drain();
            random_settings(k == 5 ? 2 : (k == 4 ? 1 : 0));
            repeat (15) gesture();
            if ($urandom_range(1)) begin
               send_event(2'($urandom), 16'($urandom), 16'($urandom), $urandom);
               send_event(EV_MOVE, 16'($urandom), 16'($urandom), $urandom);
            end
         end
      end
      drain();
      write_csr(CSR_MIN_VEL, 120); write_csr(CSR_MAX_VEL, 80);
      write_csr(CSR_DRAG_DIST, 40); write_csr(CSR_SCROLL_MS, 3000);
      write_csr(CSR_PAUSE_MS, 300);
      repeat (20) gesture();
      drain();

      if (board.pending.size() != 0) board.errors++;
      $display("sent %0d pointer events over several register settings", sent);
      $display("flings reported: %0d, mismatches: %0d", board.flings, board.errors);
      if (board.errors == 0)
         $display("fling_gesture_detector_core_test passed");
      else
         $display("fling_gesture_detector_core_test failed");
      $finish;
   end
endmodule

FILE: fling_gesture_detector_core.f
src/fgd_pkg.sv
src/fgd_div.sv
src/fgd_mul.sv
src/fling_gesture_detector_core.sv
tb/sv/fling_gesture_detector_core_test.sv
